// ----- src/pst_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pst_pkg
// Shared widths and defaults for the prime sieve lookup table.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int                LIMIT_W       = 11;
    localparam int                QUERY_W       = 10;
    localparam int                S_TDATA_W     = 16;
    localparam int                M_TDATA_W     = 8;
    localparam int                DEF_MAX_LIMIT = 1024;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 11'd1024;

endpackage : pst_pkg
`default_nettype wire

// ----- src/pst_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pst_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : pst_ram
`default_nettype wire

// ----- src/prime_sieve_table.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prime_sieve_table
// Primality lookup for numbers below a programmable limit, sieve in RAM.
// ----------------------------------------------------------------------------
// The first query after reset or after a limit write is held off while the
// mark RAM is rebuilt. The rebuild starts, fills all MAX_LIMIT entries, and
// then reads and checks each base whose square is below the limit. A base
// still marked prime has each of its multiples below the limit struck out.
// A closing check finds the next square at or above the limit, and the query
// is then taken. The rebuild is paced by the single write port of the mark
// RAM. Once built, one query beat is taken per cycle unless the output stalls;
// each beat's mark read is registered, then its result, which raises m_tvalid.
// ----------------------------------------------------------------------------
module prime_sieve_table
    import pst_pkg::*;
#(
    parameter int MAX_LIMIT = DEF_MAX_LIMIT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LIMIT_W-1:0]   cfg_wdata,   // sieve_limit
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,     // [9:0] query_number
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata      // [0] is_prime, [1] out_of_range
);

    localparam int ADDR_W = $clog2(MAX_LIMIT);
    localparam int LIM_W  = $clog2(MAX_LIMIT + 1);
    localparam int CMP_W  = ((LIM_W > LIMIT_W) ? LIM_W : LIMIT_W) + 1;

    typedef enum logic [4:0] {
        ST_SERVE    = 5'b00001,
        ST_FILL     = 5'b00010,
        ST_BASE_RD  = 5'b00100,
        ST_BASE_CHK = 5'b01000,
        ST_STRIKE   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [LIMIT_W-1:0] limit_reg, limit_next;
    logic               built_reg, built_next;
    logic [ADDR_W-1:0]  fill_reg, fill_next;
    logic [CMP_W-1:0]   base_reg, base_next;
    logic [CMP_W-1:0]   sq_reg, sq_next;
    logic [CMP_W-1:0]   mult_reg, mult_next;
    logic               p1_valid_reg, p1_valid_next;
    logic               p1_oor_reg, p1_oor_next;
    logic               m_valid_reg, m_valid_next;
    logic               m_prime_reg, m_prime_next;
    logic               m_oor_reg, m_oor_next;

    logic [CMP_W-1:0]   eff_lim;
    logic [CMP_W-1:0]   q_ext;
    logic               in_acc;
    logic               out_adv;
    logic               ram_we, ram_wdata, ram_re, ram_rdata;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;

    assign eff_lim = (CMP_W'(limit_reg) > CMP_W'(MAX_LIMIT)) ? CMP_W'(MAX_LIMIT)
                                                              : CMP_W'(limit_reg);
    assign q_ext   = CMP_W'(s_tdata[QUERY_W-1:0]);
    assign out_adv = !m_valid_reg || m_tready;

    assign s_tready  = (state_reg == ST_SERVE) && built_reg && (!p1_valid_reg || out_adv);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = (state_reg == ST_SERVE) && !p1_valid_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2){1'b0}}, m_oor_reg, m_prime_reg};

    pst_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LIMIT)
    ) u_marks (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        limit_next    = limit_reg;
        built_next    = built_reg;
        fill_next     = fill_reg;
        base_next     = base_reg;
        sq_next       = sq_reg;
        mult_next     = mult_reg;
        p1_valid_next = p1_valid_reg;
        p1_oor_next   = p1_oor_reg;
        m_valid_next  = m_valid_reg;
        m_prime_next  = m_prime_reg;
        m_oor_next    = m_oor_reg;
        ram_we        = 1'b0;
        ram_waddr     = fill_reg;
        ram_wdata     = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = q_ext[ADDR_W-1:0];

        // result path
        if (out_adv) begin
            m_valid_next = p1_valid_reg;
            if (p1_valid_reg) begin
                m_prime_next = !p1_oor_reg && ram_rdata;
                m_oor_next   = p1_oor_reg;
            end
        end
        if (!p1_valid_reg || out_adv) begin
            p1_valid_next = in_acc;
        end

        case (state_reg)
            ST_SERVE: begin
                if (in_acc) begin
                    ram_re      = 1'b1;
                    p1_oor_next = q_ext >= eff_lim;
                end
                if (cfg_valid && cfg_ready) begin
                    limit_next = cfg_wdata;
                    built_next = 1'b0;
                end else if (s_tvalid && !built_reg && !p1_valid_reg) begin
                    fill_next  = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = fill_reg;
                ram_wdata = fill_reg >= ADDR_W'(2);
                fill_next = fill_reg + ADDR_W'(1);
                if (fill_reg == ADDR_W'(MAX_LIMIT - 1)) begin
                    base_next  = CMP_W'(2);
                    sq_next    = CMP_W'(4);
                    state_next = ST_BASE_RD;
                end
            end
            ST_BASE_RD: begin
                if (sq_reg < eff_lim) begin
                    ram_re     = 1'b1;
                    ram_raddr  = base_reg[ADDR_W-1:0];
                    state_next = ST_BASE_CHK;
                end else begin
                    built_next = 1'b1;
                    state_next = ST_SERVE;
                end
            end
            ST_BASE_CHK: begin
                if (ram_rdata) begin
                    mult_next  = sq_reg;
                    state_next = ST_STRIKE;
                end else begin
                    base_next  = base_reg + CMP_W'(1);
                    sq_next    = sq_reg + (base_reg << 1) + CMP_W'(1);
                    state_next = ST_BASE_RD;
                end
            end
            ST_STRIKE: begin
                if (mult_reg < eff_lim) begin
                    ram_we    = 1'b1;
                    ram_waddr = mult_reg[ADDR_W-1:0];
                    mult_next = mult_reg + base_reg;
                end else begin
                    base_next  = base_reg + CMP_W'(1);
                    sq_next    = sq_reg + (base_reg << 1) + CMP_W'(1);
                    state_next = ST_BASE_RD;
                end
            end
            default: begin
                state_next = ST_SERVE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SERVE;
            limit_reg    <= LIMIT_RESET;
            built_reg    <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            limit_reg    <= limit_next;
            built_reg    <= built_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_reg    <= fill_next;
        base_reg    <= base_next;
        sq_reg      <= sq_next;
        mult_reg    <= mult_next;
        p1_oor_reg  <= p1_oor_next;
        m_prime_reg <= m_prime_next;
        m_oor_reg   <= m_oor_next;
    end

    // no query is taken against a stale table
    a_ready_built: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> built_reg)
        else $error("query accepted before table built");

    // the mark RAM is never written while queries are being served
    a_no_write_serve: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SERVE) |-> !ram_we)
        else $error("mark write while serving");

    // an accepted query has its read in flight on the next cycle
    a_acc_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> p1_valid_reg)
        else $error("accepted beat lost");

    // a rebuild never starts with a read still in flight
    a_build_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FILL) |-> !p1_valid_reg)
        else $error("rebuild overlaps an in-flight read");

endmodule : prime_sieve_table
`default_nettype wire
